/* rtl/core/bmp_pixel_to_framebuffer_defines.svh */
// Assertion macros used by the checker of the BMP unpacker.
// No dependencies; expects signals clk and rst_n in the using scope.
`ifndef BMP_PIXEL_TO_FRAMEBUFFER_DEFINES_SVH
`define BMP_PIXEL_TO_FRAMEBUFFER_DEFINES_SVH

// Same-cycle implication, disabled in reset
`define BMP_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bmp unpacker check failed");

// Next-cycle implication, disabled in reset
`define BMP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bmp unpacker check failed");

`endif

/* rtl/core/bmp_p2fb_pkg.sv */
// Types, constants and register codes of the BMP pixel-array unpacker.
// No dependencies.
package bmp_p2fb_pkg;

    localparam int SCREEN_WIDTH  = 800;
    localparam int SCREEN_HEIGHT = 480;
    localparam int MAX_IMAGE_DIM = 4095;
    localparam int QUEUE_DEPTH   = 4;

    localparam int DIM_W   = 12;
    localparam int ORG_W   = 13;
    localparam int INDEX_W = 19;
    localparam int COLOR_W = 32;
    localparam int X_W     = $clog2(SCREEN_WIDTH);
    localparam int Y_W     = $clog2(SCREEN_HEIGHT);
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;
    localparam int FB_SIZE    = SCREEN_WIDTH * SCREEN_HEIGHT;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH    = 3'd0,
        REG_IMAGE_HEIGHT   = 3'd1,
        REG_MIRROR_COLUMNS = 3'd2,
        REG_BOTTOM_UP      = 3'd3,
        REG_DEPTH_IS_32    = 3'd4,
        REG_ORIGIN_X       = 3'd5,
        REG_ORIGIN_Y       = 3'd6
    } reg_index_t;

    typedef enum logic [1:0] {
        PH_BLUE  = 2'd0,
        PH_GREEN = 2'd1,
        PH_RED   = 2'd2,
        PH_ALPHA = 2'd3
    } phase_t;

    // Effective configuration as seen by front and back
    typedef struct packed {
        logic [DIM_W-1:0]        width;
        logic [DIM_W-1:0]        height;
        logic                    mirror_columns;
        logic                    bottom_up;
        logic                    depth_is_32;
        logic [1:0]              pad_len;
        logic signed [ORG_W-1:0] origin_x;
        logic signed [ORG_W-1:0] origin_y;
    } cfg_t;

    // One finished pixel handed from front to back
    typedef struct packed {
        logic [DIM_W-1:0]   column;
        logic [DIM_W-1:0]   row;
        logic [COLOR_W-1:0] color;
        logic               last_col;
        logic               last_row;
    } pix_rec_t;

endpackage

/* rtl/core/bmp_p2fb_ifs.sv */
// Valid/ready channel interfaces of the BMP unpacker: byte input,
// framebuffer write output and configuration write. Depends on bmp_p2fb_pkg.
interface bmp_p2fb_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] pixel_byte;
    modport source (output valid, output pixel_byte, input ready);
    modport sink (input valid, input pixel_byte, output ready);
endinterface

interface bmp_p2fb_fb_if;
    logic                             valid;
    logic                             ready;
    logic [bmp_p2fb_pkg::INDEX_W-1:0] fb_index;
    logic [bmp_p2fb_pkg::COLOR_W-1:0] pixel_color;
    logic                             last_pixel;
    modport source (output valid, output fb_index, output pixel_color,
                    output last_pixel, input ready);
    modport sink (input valid, input fb_index, input pixel_color,
                  input last_pixel, output ready);
endinterface

interface bmp_p2fb_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [bmp_p2fb_pkg::CFG_IDX_W-1:0]  index;
    logic [bmp_p2fb_pkg::CFG_DATA_W-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

/* rtl/core/bmp_pixel_to_framebuffer.sv */
// BMP pixel-array unpacker. One pixel-array byte (padding included) is taken
// per clock, sustained, as long as the framebuffer side keeps up; a finished
// pixel reaches the framebuffer write via the queue, stage 1 and output register.
// The pixel queue (QUEUE_DEPTH entries) between the byte front end and the
// mapping back end absorbs output stalls; the front stops only when it is full.
// Configuration writes are taken every cycle; write them while the block is idle.
// Depends on bmp_p2fb_pkg, bmp_p2fb_ifs, front, queue and back modules.
module bmp_pixel_to_framebuffer #(
    parameter int QUEUE_DEPTH = bmp_p2fb_pkg::QUEUE_DEPTH
) (
    input  logic          clk,
    input  logic          rst_n,
    bmp_p2fb_cfg_if.sink  cfg,
    bmp_p2fb_byte_if.sink pixel_in,
    bmp_p2fb_fb_if.source fb_write
);
    import bmp_p2fb_pkg::*;

    logic [DIM_W-1:0]        image_width_reg;
    logic [DIM_W-1:0]        image_height_reg;
    logic                    mirror_columns_reg;
    logic                    bottom_up_reg;
    logic                    depth_is_32_reg;
    logic signed [ORG_W-1:0] origin_x_reg;
    logic signed [ORG_W-1:0] origin_y_reg;

    cfg_t             cfg_eff;
    logic [DIM_W-1:0] w_eff;
    logic [DIM_W-1:0] h_eff;
    logic             push_valid;
    logic             push_ready;
    pix_rec_t         push_rec;
    logic             pop_valid;
    logic             pop_ready;
    pix_rec_t         pop_rec;

    assign cfg.ready = 1'b1;

    // Register file writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg    <= DIM_W'(800);
            image_height_reg   <= DIM_W'(480);
            mirror_columns_reg <= 1'b0;
            bottom_up_reg      <= 1'b1;
            depth_is_32_reg    <= 1'b0;
            origin_x_reg       <= '0;
            origin_y_reg       <= '0;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_IMAGE_WIDTH:    image_width_reg    <= cfg.data[DIM_W-1:0];
                REG_IMAGE_HEIGHT:   image_height_reg   <= cfg.data[DIM_W-1:0];
                REG_MIRROR_COLUMNS: mirror_columns_reg <= cfg.data[0];
                REG_BOTTOM_UP:      bottom_up_reg      <= cfg.data[0];
                REG_DEPTH_IS_32:    depth_is_32_reg    <= cfg.data[0];
                REG_ORIGIN_X:       origin_x_reg       <= $signed(cfg.data[ORG_W-1:0]);
                REG_ORIGIN_Y:       origin_y_reg       <= $signed(cfg.data[ORG_W-1:0]);
                default:            ;
            endcase
        end
    end

    // Effective sizes: zero acts as one, clamp to the largest image
    always_comb
    begin
        w_eff = (image_width_reg == '0) ? DIM_W'(1) : image_width_reg;
        h_eff = (image_height_reg == '0) ? DIM_W'(1) : image_height_reg;
        if ({1'b0, w_eff} > (DIM_W+1)'(MAX_IMAGE_DIM))
        begin
            w_eff = DIM_W'(MAX_IMAGE_DIM);
        end
        if ({1'b0, h_eff} > (DIM_W+1)'(MAX_IMAGE_DIM))
        begin
            h_eff = DIM_W'(MAX_IMAGE_DIM);
        end
    end

    // Row padding is w mod 4 bytes in 24-bit mode, none in 32-bit mode
    assign cfg_eff.width          = w_eff;
    assign cfg_eff.height         = h_eff;
    assign cfg_eff.mirror_columns = mirror_columns_reg;
    assign cfg_eff.bottom_up      = bottom_up_reg;
    assign cfg_eff.depth_is_32    = depth_is_32_reg;
    assign cfg_eff.pad_len        = depth_is_32_reg ? 2'd0 : w_eff[1:0];
    assign cfg_eff.origin_x       = origin_x_reg;
    assign cfg_eff.origin_y       = origin_y_reg;

    bmp_p2fb_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_eff    (cfg_eff),
        .pixel_in   (pixel_in),
        .push_ready (push_ready),
        .push_valid (push_valid),
        .push_rec   (push_rec)
    );

    bmp_p2fb_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_rec   (push_rec),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_rec    (pop_rec)
    );

    bmp_p2fb_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_eff   (cfg_eff),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_rec   (pop_rec),
        .fb_write  (fb_write)
    );

endmodule

/* rtl/core/bmp_p2fb_front.sv */
// Front end: takes pixel-array bytes, gathers B,G,R(,A), skips row padding
// and tracks column/row. Depends on bmp_p2fb_pkg and bmp_p2fb_ifs.
module bmp_p2fb_front (
    input  logic                      clk,
    input  logic                      rst_n,
    input  bmp_p2fb_pkg::cfg_t        cfg_eff,
    bmp_p2fb_byte_if.sink             pixel_in,
    input  logic                      push_ready,
    output logic                      push_valid,
    output bmp_p2fb_pkg::pix_rec_t    push_rec
);
    import bmp_p2fb_pkg::*;

    phase_t           phase_reg, phase_next;
    logic [7:0]       blue_reg, blue_next;
    logic [7:0]       green_reg, green_next;
    logic [7:0]       red_reg, red_next;
    logic [DIM_W-1:0] col_reg, col_next;
    logic [DIM_W-1:0] row_reg, row_next;
    logic [1:0]       pad_reg, pad_next;
    logic             in_pad_reg, in_pad_next;

    logic             accept;
    logic             last_col;
    logic             last_row;
    logic [DIM_W-1:0] row_adv;
    logic [1:0]       pad_inc;
    logic [7:0]       alpha;
    logic [7:0]       red_out;

    assign pixel_in.ready = push_ready;
    assign accept = pixel_in.valid && push_ready;

    // Position compares, one wider so a full-range size still compares
    assign last_col = ({1'b0, col_reg} + 13'd1) >= {1'b0, cfg_eff.width};
    assign last_row = ({1'b0, row_reg} + 13'd1) >= {1'b0, cfg_eff.height};
    assign row_adv  = last_row ? '0 : row_reg + 12'd1;
    assign pad_inc  = pad_reg + 2'd1;

    // Color of a completing pixel: alpha from the byte in 32-bit mode
    assign alpha   = cfg_eff.depth_is_32 ? pixel_in.pixel_byte : 8'd0;
    assign red_out = cfg_eff.depth_is_32 ? red_reg : pixel_in.pixel_byte;

    assign push_rec.column   = col_reg;
    assign push_rec.row      = row_reg;
    assign push_rec.color    = {alpha, red_out, green_reg, blue_reg};
    assign push_rec.last_col = last_col;
    assign push_rec.last_row = last_row;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_BLUE;
            blue_reg   <= '0;
            green_reg  <= '0;
            red_reg    <= '0;
            col_reg    <= '0;
            row_reg    <= '0;
            pad_reg    <= '0;
            in_pad_reg <= 1'b0;
        end
        else
        begin
            phase_reg  <= phase_next;
            blue_reg   <= blue_next;
            green_reg  <= green_next;
            red_reg    <= red_next;
            col_reg    <= col_next;
            row_reg    <= row_next;
            pad_reg    <= pad_next;
            in_pad_reg <= in_pad_next;
        end
    end

    // Classify the byte: padding, color byte, or pixel completion
    always_comb
    begin
        phase_next  = phase_reg;
        blue_next   = blue_reg;
        green_next  = green_reg;
        red_next    = red_reg;
        col_next    = col_reg;
        row_next    = row_reg;
        pad_next    = pad_reg;
        in_pad_next = in_pad_reg;
        push_valid  = 1'b0;
        if (accept)
        begin
            if (in_pad_reg)
            begin
                // End the row once the padding length is reached
                if (pad_inc == 2'd0 || pad_inc >= cfg_eff.pad_len)
                begin
                    in_pad_next = 1'b0;
                    pad_next    = '0;
                    row_next    = row_adv;
                end
                else
                begin
                    pad_next = pad_inc;
                end
            end
            else if (phase_reg == PH_BLUE)
            begin
                blue_next  = pixel_in.pixel_byte;
                phase_next = PH_GREEN;
            end
            else if (phase_reg == PH_GREEN)
            begin
                green_next = pixel_in.pixel_byte;
                phase_next = PH_RED;
            end
            else if (phase_reg == PH_RED && cfg_eff.depth_is_32)
            begin
                red_next   = pixel_in.pixel_byte;
                phase_next = PH_ALPHA;
            end
            else
            begin
                // Pixel complete: hand it to the back end, advance position
                push_valid = 1'b1;
                red_next   = red_out;
                phase_next = PH_BLUE;
                if (last_col)
                begin
                    col_next = '0;
                    if (cfg_eff.pad_len != 2'd0)
                    begin
                        in_pad_next = 1'b1;
                        pad_next    = '0;
                    end
                    else
                    begin
                        row_next = row_adv;
                    end
                end
                else
                begin
                    col_next = col_reg + 12'd1;
                end
            end
        end
    end

endmodule

/* rtl/core/bmp_p2fb_queue.sv */
// Short pixel queue between front and back ends.
// Depends on bmp_p2fb_pkg.
module bmp_p2fb_queue #(
    parameter int DEPTH = bmp_p2fb_pkg::QUEUE_DEPTH
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push_valid,
    output logic                   push_ready,
    input  bmp_p2fb_pkg::pix_rec_t push_rec,
    output logic                   pop_valid,
    input  logic                   pop_ready,
    output bmp_p2fb_pkg::pix_rec_t pop_rec
);
    import bmp_p2fb_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    pix_rec_t         slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign push_ready = count_reg != CNT_W'(DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_rec    = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Advance pointers with wrap at the depth
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store payload on push
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_rec;
        end
    end

endmodule

/* rtl/core/bmp_p2fb_back.sv */
// Back end: maps column/row to a screen point, drops off-screen pixels,
// forms the framebuffer index. Depends on bmp_p2fb_pkg and bmp_p2fb_ifs.
module bmp_p2fb_back (
    input  logic                   clk,
    input  logic                   rst_n,
    input  bmp_p2fb_pkg::cfg_t     cfg_eff,
    input  logic                   pop_valid,
    output logic                   pop_ready,
    input  bmp_p2fb_pkg::pix_rec_t pop_rec,
    bmp_p2fb_fb_if.source          fb_write
);
    import bmp_p2fb_pkg::*;

    localparam int POS_W = 15;

    // Stage 1: screen point
    logic               s1_valid_reg;
    logic               s1_on_reg;
    logic [X_W-1:0]     s1_x_reg;
    logic [Y_W-1:0]     s1_y_reg;
    logic [COLOR_W-1:0] s1_color_reg;
    logic               s1_last_reg;

    // Output register
    logic               out_valid_reg;
    logic [INDEX_W-1:0] out_index_reg;
    logic [COLOR_W-1:0] out_color_reg;
    logic               out_last_reg;

    logic                    out_load;
    logic                    s1_load;
    logic signed [POS_W-1:0] col_s, row_s, w_s, h_s, ox_s, oy_s;
    logic signed [POS_W-1:0] sx, sy;
    logic                    on_screen;
    logic [INDEX_W-1:0]      index_calc;

    assign out_load  = !out_valid_reg || fb_write.ready;
    assign s1_load   = !s1_valid_reg || out_load;
    assign pop_ready = s1_load;

    // Signed view of counters, sizes and origin
    assign col_s = $signed({3'b000, pop_rec.column});
    assign row_s = $signed({3'b000, pop_rec.row});
    assign w_s   = $signed({3'b000, cfg_eff.width});
    assign h_s   = $signed({3'b000, cfg_eff.height});
    assign ox_s  = POS_W'(cfg_eff.origin_x);
    assign oy_s  = POS_W'(cfg_eff.origin_y);

    // Place the point, flipping as configured
    assign sx = cfg_eff.mirror_columns ? ox_s + w_s - 15'sd1 - col_s : ox_s + col_s;
    assign sy = cfg_eff.bottom_up ? oy_s + h_s - 15'sd1 - row_s : oy_s + row_s;
    assign on_screen = !sx[POS_W-1] && (sx < POS_W'(SCREEN_WIDTH))
                    && !sy[POS_W-1] && (sy < POS_W'(SCREEN_HEIGHT));

    // Row times screen width plus column
    assign index_calc = INDEX_W'(s1_y_reg) * INDEX_W'(SCREEN_WIDTH) + INDEX_W'(s1_x_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_load)
            begin
                s1_valid_reg <= pop_valid;
            end
            if (out_load)
            begin
                out_valid_reg <= s1_valid_reg && s1_on_reg;
            end
        end
    end

    // Payload: advance with the stage enables
    always_ff @(posedge clk)
    begin
        if (s1_load && pop_valid)
        begin
            s1_on_reg    <= on_screen;
            s1_x_reg     <= sx[X_W-1:0];
            s1_y_reg     <= sy[Y_W-1:0];
            s1_color_reg <= pop_rec.color;
            s1_last_reg  <= pop_rec.last_col && pop_rec.last_row;
        end
        if (out_load && s1_valid_reg)
        begin
            out_index_reg <= index_calc;
            out_color_reg <= s1_color_reg;
            out_last_reg  <= s1_last_reg;
        end
    end

    assign fb_write.valid       = out_valid_reg;
    assign fb_write.fb_index    = out_index_reg;
    assign fb_write.pixel_color = out_color_reg;
    assign fb_write.last_pixel  = out_last_reg;

endmodule

/* rtl/core/bmp_p2fb_checker.sv */
// Port-level checks of the BMP unpacker and the bind that attaches them.
// Depends on bmp_p2fb_pkg and bmp_pixel_to_framebuffer_defines.svh.
`include "bmp_pixel_to_framebuffer_defines.svh"

module bmp_p2fb_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             in_valid,
    input logic                             in_ready,
    input logic                             fb_valid,
    input logic                             fb_ready,
    input logic [bmp_p2fb_pkg::INDEX_W-1:0] fb_index,
    input logic [bmp_p2fb_pkg::COLOR_W-1:0] fb_color,
    input logic                             fb_last
);
    import bmp_p2fb_pkg::*;

    logic seen_input_reg;

    // Remember that some byte has been taken since reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_input_reg <= 1'b0;
        end
        else if (in_valid && in_ready)
        begin
            seen_input_reg <= 1'b1;
        end
    end

    `BMP_ASSERT_NEXT(a_fb_hold, fb_valid && !fb_ready, fb_valid)
    `BMP_ASSERT_NEXT(a_fb_stable, fb_valid && !fb_ready, $stable(fb_index) && $stable(fb_color) && $stable(fb_last))
    `BMP_ASSERT_NOW(a_index_range, fb_valid, fb_index < INDEX_W'(FB_SIZE))
    `BMP_ASSERT_NOW(a_no_write_without_input, fb_valid, seen_input_reg)

endmodule

bind bmp_pixel_to_framebuffer bmp_p2fb_checker u_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (pixel_in.valid),
    .in_ready (pixel_in.ready),
    .fb_valid (fb_write.valid),
    .fb_ready (fb_write.ready),
    .fb_index (fb_write.fb_index),
    .fb_color (fb_write.pixel_color),
    .fb_last  (fb_write.last_pixel)
);
